// ===== rtl/length_prefixed_deframer_macros.svh =====
// Assertion macros for the length-prefixed deframer.
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("deframer assertion failed");

`endif

// ===== rtl/lpd_pkg.sv =====
// Shared constants and types of the length-prefixed deframer.
package lpd_pkg;

    localparam int unsigned HDR_BYTES     = 4;
    localparam int unsigned HDR_CNT_W     = 2;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ADDR_W        = 3;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned REG_SEL_BIT   = 2;

    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 32'd65536;
    localparam logic                 REG_MAX_LEN   = 1'b0;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST      = HDR_CNT_W'(HDR_BYTES - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        logic              bad_length;
    } t_result;

endpackage

// ===== rtl/lpd_cfg.sv =====
// APB-style register port holding the maximum frame length.
module lpd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpd_pkg::ADDR_W-1:0]       paddr,
    input  logic [lpd_pkg::DATA_W-1:0]       pwdata,
    output logic [lpd_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    output logic [lpd_pkg::LEN_W-1:0]        o_max_len
);

    logic [lpd_pkg::LEN_W-1:0] r_max_len;
    logic                      w_sel_max;

    assign w_sel_max = (paddr[lpd_pkg::REG_SEL_BIT] == lpd_pkg::REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpd_pkg::MAX_LEN_RESET;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_len <= pwdata;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = w_sel_max ? r_max_len : '0;
    assign o_max_len = r_max_len;

endmodule

// ===== rtl/lpd_core.sv =====
// Header collection, length check and payload forwarding with result register.
module lpd_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lpd_pkg::LEN_W-1:0]         i_max_len,
    input  logic                              i_valid,
    input  logic [lpd_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                              o_stall,
    output logic                              o_valid,
    output lpd_pkg::t_result                  o_result,
    input  logic                              i_stall
);

    logic [23:0]                     r_hdr, n_hdr;
    logic [lpd_pkg::HDR_CNT_W-1:0]   r_cnt, n_cnt;
    logic [lpd_pkg::LEN_W-1:0]       r_left, n_left;
    logic                            r_closed, n_closed;
    logic                            r_out_valid, n_out_valid;
    lpd_pkg::t_result                r_res, n_res;
    logic                            w_take;
    logic [lpd_pkg::LEN_W-1:0]       w_len;

    assign o_stall = r_out_valid && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign w_len   = {r_hdr, i_rx_byte};

    always_comb begin
        n_hdr       = r_hdr;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_closed    = r_closed;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_stall;
        if (w_take && !r_closed) begin
            if (r_left != '0) begin
                n_left             = r_left - lpd_pkg::LEN_W'(1);
                n_res.payload_byte = i_rx_byte;
                n_res.frame_end    = (r_left == lpd_pkg::LEN_W'(1));
                n_res.bad_length   = 1'b0;
                n_out_valid        = 1'b1;
            end else if (r_cnt != lpd_pkg::HDR_LAST) begin
                n_hdr = {r_hdr[15:0], i_rx_byte};
                n_cnt = r_cnt + lpd_pkg::HDR_CNT_W'(1);
            end else begin
                n_hdr = '0;
                n_cnt = '0;
                if ((w_len == '0) || (w_len > i_max_len)) begin
                    n_closed           = 1'b1;
                    n_res.payload_byte = '0;
                    n_res.frame_end    = 1'b0;
                    n_res.bad_length   = 1'b1;
                    n_out_valid        = 1'b1;
                end else begin
                    n_left = w_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= '0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr       <= n_hdr;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_closed    <= n_closed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/length_prefixed_deframer.sv =====
// Top level of the length-prefixed deframer: register port, deframing core, checks.
//
// Input channel: one received byte per transaction (i_valid, i_rx_byte, o_stall).
// Output channel: one result per payload byte or one error result
// (o_valid, o_payload_byte, o_frame_end, o_bad_length, i_stall).
// Each frame starts with a 4-byte big-endian length; header bytes give no result.
// A payload byte appears at the output in the cycle after its input transaction.
// Throughput: one byte per cycle unless the receiver stalls, set by the single result
// register; a new byte is taken in the same cycle that the held result is taken.
// A length of zero or above max_frame_length gives one result with o_bad_length
// set, after which every byte is taken and dropped until reset.
// While the receiver stalls with a result held, o_stall is raised and the
// result holds.
// Reset (synchronous, active low) clears the header, the count, the remaining
// length, the closed flag and the output valid; max_frame_length returns to 65536.
// Register map: max_frame_length at byte address 0, written through the APB port.
`include "length_prefixed_deframer_macros.svh"
module length_prefixed_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpd_pkg::ADDR_W-1:0]       paddr,
    input  logic [lpd_pkg::DATA_W-1:0]       pwdata,
    output logic [lpd_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             i_valid,
    input  logic [lpd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [lpd_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                             o_frame_end,
    output logic                             o_bad_length,
    input  logic                             i_stall
);

    logic [lpd_pkg::LEN_W-1:0] w_max_len;
    lpd_pkg::t_result          w_result;

    lpd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    lpd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_len (w_max_len),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_result  (w_result),
        .i_stall   (i_stall)
    );

    assign o_payload_byte = w_result.payload_byte;
    assign o_frame_end    = w_result.frame_end;
    assign o_bad_length   = w_result.bad_length;

    `LPD_ASSERT_SAME(a_stall_needs_result, o_stall, o_valid && i_stall)
    `LPD_ASSERT_SAME(a_error_fields, o_valid && o_bad_length, (o_payload_byte == '0) && !o_frame_end)
    `LPD_ASSERT_NEXT(a_closed_is_silent, o_valid && o_bad_length && !i_stall, !o_valid)

endmodule
